@@ src/fed_pkg.sv @@
// ----------------------------------------------------------------------------
// fed_pkg
// Widths, constants and register map for the feedback echo delay line.
// ----------------------------------------------------------------------------
package fed_pkg;

    localparam int unsigned FED_STORE_DEPTH = 8192;

    // Payload and store widths
    localparam int CFG_W    = 14;
    localparam int SAMPLE_W = 10;
    localparam int ECHO_W   = 8;
    localparam int STORE_W  = 9;

    // Feedback gain: (old * 110) >> 8
    localparam int GAIN_W     = 7;
    localparam int GAIN_SHIFT = 8;
    localparam int PROD1_W    = STORE_W + GAIN_W;
    localparam int F_W        = PROD1_W - GAIN_SHIFT;

    // Division by 2.5: floor(2 * sum / 5), /5 as multiply by ceil(2^18 / 5)
    localparam int SUM_W       = SAMPLE_W + 1;
    localparam int X_W         = SUM_W + 1;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD2_W     = X_W + RECIP_W;
    localparam int QUOT_W      = PROD2_W - RECIP_SHIFT;

    localparam logic [CFG_W-1:0]   DELAY_RESET = 14'd8000;
    localparam logic [STORE_W-1:0] STORE_RESET = 9'd127;
    localparam logic [STORE_W-1:0] STORE_MAX   = 9'd511;
    localparam logic [GAIN_W-1:0]  FB_GAIN     = 7'd110;
    localparam logic [RECIP_W-1:0] RECIP_FIVE  = 16'd52429;

    // Shortest delay length that lets items overlap in the pipeline
    localparam int MIN_PIPE_LEN = 5;

    // Register port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic REG_DELAY_LENGTH = 1'b0;

endpackage

@@ src/fed_cfg.sv @@
// ----------------------------------------------------------------------------
// fed_cfg
// Register port holding delay_length; derives the effective wrap length and
// whether items must run one at a time.
// ----------------------------------------------------------------------------
module fed_cfg import fed_pkg::*; #(
    parameter int unsigned STORE_DEPTH = FED_STORE_DEPTH,
    localparam int LEN_W = $clog2(STORE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [LEN_W-1:0]   o_eff_len,
    output logic               o_seq_mode
);

    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic [CFG_W-1:0] r_delay_length;
    logic [CMP_W-1:0] len_ext;
    logic             sel_len;

    assign sel_len = (paddr[REG_IDX_LSB] == REG_DELAY_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = sel_len ? PDATA_W'(r_delay_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= DELAY_RESET;
        end else if (psel && penable && pwrite && sel_len) begin
            r_delay_length <= pwdata[CFG_W-1:0];
        end
    end

    // zero acts as one, anything beyond the store saturates
    assign len_ext = CMP_W'(r_delay_length);

    always_comb begin
        if (r_delay_length == '0) begin
            o_eff_len = LEN_W'(1);
        end else if (len_ext > CMP_W'(STORE_DEPTH)) begin
            o_eff_len = LEN_W'(STORE_DEPTH);
        end else begin
            o_eff_len = len_ext[LEN_W-1:0];
        end
    end

    assign o_seq_mode = (CMP_W'(o_eff_len) < CMP_W'(MIN_PIPE_LEN));

endmodule

@@ src/fed_core.sv @@
// ----------------------------------------------------------------------------
// fed_core
// Delay store and its read-modify-write pipeline. Each transaction reads the
// entry at the next pointer; that value is both this item's echo and the
// next item's feedback operand. The write-back lands three stages later.
// ----------------------------------------------------------------------------
module fed_core import fed_pkg::*; #(
    parameter int unsigned STORE_DEPTH = FED_STORE_DEPTH,
    localparam int ADDR_W = $clog2(STORE_DEPTH),
    localparam int LEN_W  = $clog2(STORE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ECHO_W-1:0]   o_echo_out,
    input  logic [LEN_W-1:0]    i_eff_len,
    input  logic                i_seq_mode
);

    logic [STORE_W-1:0] mem [STORE_DEPTH];
    logic [STORE_W-1:0] r_rdata;

    logic [ADDR_W-1:0]  r_ptr;
    logic [LEN_W-1:0]   r_fill;
    logic [STORE_W-1:0] r_old;

    // stage 1: read data returns
    logic                r_p1_valid;
    logic [SAMPLE_W-1:0] r_p1_sample;
    logic [ADDR_W-1:0]   r_p1_ptr;
    logic                r_p1_self;
    logic                r_p1_hit;

    // stage 2: feedback term ready
    logic                r_p2_valid;
    logic [SAMPLE_W-1:0] r_p2_sample;
    logic [F_W-1:0]      r_p2_f;
    logic [ADDR_W-1:0]   r_p2_ptr;
    logic                r_p2_self;
    logic [STORE_W-1:0]  r_p2_echo;

    // stage 3: quotient ready, write-back
    logic                r_p3_valid;
    logic [QUOT_W-1:0]   r_p3_quot;
    logic [ADDR_W-1:0]   r_p3_ptr;
    logic                r_p3_self;
    logic [STORE_W-1:0]  r_p3_echo;

    logic                r_out_valid;
    logic [ECHO_W-1:0]   r_echo_out;

    logic en1, en2, en3, room, busy, accept_ok, accept, wr_en;
    logic [LEN_W-1:0]   ptr_inc;
    logic [ADDR_W-1:0]  nptr;
    logic [STORE_W-1:0] rd_echo;
    logic [PROD1_W-1:0] old_prod;
    logic [SUM_W-1:0]   sum;
    logic [X_W-1:0]     x;
    logic [PROD2_W-1:0] quot_prod;
    logic [STORE_W-1:0] new_val;
    logic [STORE_W-1:0] echo_val;

    // stages advance into any free slot, so bubbles collapse under output stall
    assign en3  = !r_out_valid || !i_stall;
    assign en2  = !r_p3_valid || en3;
    assign en1  = !r_p2_valid || en2;
    assign room = !r_p1_valid || en1;
    assign busy = r_p1_valid || r_p2_valid || r_p3_valid;

    // short lengths revisit an entry before its write-back lands: run singly
    assign accept_ok = room && (!i_seq_mode || !busy);
    assign accept    = i_valid && accept_ok;
    assign o_stall   = !accept_ok;

    assign ptr_inc = LEN_W'(r_ptr) + LEN_W'(1);
    assign nptr    = (ptr_inc >= i_eff_len) ? '0 : ptr_inc[ADDR_W-1:0];

    // stage 1 math
    assign rd_echo  = r_p1_hit ? r_rdata : STORE_RESET;
    assign old_prod = PROD1_W'(r_old) * PROD1_W'(FB_GAIN);

    // stage 2 math
    assign sum       = SUM_W'(r_p2_sample) + SUM_W'(r_p2_f);
    assign x         = {sum, 1'b0};
    assign quot_prod = PROD2_W'(x) * PROD2_W'(RECIP_FIVE);

    // stage 3 math
    assign new_val  = (r_p3_quot > QUOT_W'(STORE_MAX)) ? STORE_MAX
                                                       : r_p3_quot[STORE_W-1:0];
    assign echo_val = r_p3_self ? new_val : r_p3_echo;
    assign wr_en    = en3 && r_p3_valid;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= mem[nptr];
        end
        if (wr_en) begin
            mem[r_p3_ptr] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_fill      <= '0;
            r_old       <= STORE_RESET;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_ptr      <= nptr;
                r_p1_valid <= 1'b1;
            end else if (en1) begin
                r_p1_valid <= 1'b0;
            end
            if (en1) begin
                r_p2_valid <= r_p1_valid;
            end
            if (en2) begin
                r_p3_valid <= r_p2_valid;
            end
            if (en3) begin
                r_out_valid <= r_p3_valid;
            end
            // feedback operand for the next item
            if (en1 && r_p1_valid && !r_p1_self) begin
                r_old <= rd_echo;
            end else if (wr_en && r_p3_self) begin
                r_old <= new_val;
            end
            // entries are written in pointer order, so written ones form a prefix
            if (wr_en && (LEN_W'(r_p3_ptr) == r_fill)) begin
                r_fill <= r_fill + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_sample <= i_sample;
            r_p1_ptr    <= r_ptr;
            r_p1_self   <= (nptr == r_ptr);
            r_p1_hit    <= (LEN_W'(nptr) < r_fill);
        end
        if (en1) begin
            r_p2_sample <= r_p1_sample;
            r_p2_f      <= old_prod[PROD1_W-1:GAIN_SHIFT];
            r_p2_ptr    <= r_p1_ptr;
            r_p2_self   <= r_p1_self;
            r_p2_echo   <= rd_echo;
        end
        if (en2) begin
            r_p3_quot <= quot_prod[PROD2_W-1:RECIP_SHIFT];
            r_p3_ptr  <= r_p2_ptr;
            r_p3_self <= r_p2_self;
            r_p3_echo <= r_p2_echo;
        end
        if (en3) begin
            r_echo_out <= echo_val[STORE_W-1:1];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_echo_out = r_echo_out;

endmodule

@@ src/feedback_echo_delay_line_top.sv @@
// ----------------------------------------------------------------------------
// feedback_echo_delay_line_top
// Pipeline: a taken input passes through the core's stage registers to the output.
// Throughput: one item per cycle for effective delay length 5 and up, unless
//   the output stalls; below that an item waits until the stage registers empty,
//   as each write-back must land in the store before the same entry is read again.
// Reset: pointer 0, delay length 8000; a fill count makes unwritten entries
//   read as 127, so there is no clearing pass.
// ----------------------------------------------------------------------------
module feedback_echo_delay_line_top import fed_pkg::*; #(
    parameter int unsigned STORE_DEPTH = FED_STORE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ECHO_W-1:0]   o_echo_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int LEN_W = $clog2(STORE_DEPTH + 1);

    logic [LEN_W-1:0] eff_len;
    logic             seq_mode;

    fed_cfg #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_len (eff_len),
        .o_seq_mode(seq_mode)
    );

    fed_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_echo_out(o_echo_out),
        .i_eff_len (eff_len),
        .i_seq_mode(seq_mode)
    );

endmodule

@@ src/fed_checker.sv @@
// ----------------------------------------------------------------------------
// fed_checker
// Port-level checks on the echo delay line: transaction accounting, output
// range, hold under output stall and reset behavior.
// ----------------------------------------------------------------------------
module fed_checker import fed_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [ECHO_W-1:0] o_echo_out
);

    // stored values never exceed 494, so the halved echo stays at or below 247
    localparam logic [ECHO_W-1:0] ECHO_PEAK     = 8'd247;
    localparam logic [2:0]        MAX_IN_FLIGHT = 3'd4;

    logic       in_acc, out_acc;
    logic [2:0] r_cnt;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_cnt != 3'd0))
        else $error("result delivered without an outstanding transaction");

    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_IN_FLIGHT)
        else $error("more transactions in flight than pipeline slots");

    a_echo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_echo_out <= ECHO_PEAK))
        else $error("echo value beyond reachable range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_echo_out)))
        else $error("stalled result changed or dropped");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind feedback_echo_delay_line_top fed_checker u_fed_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_echo_out(o_echo_out)
);
